// ===== design/dfe_pkg.sv =====
package dfe_pkg;

  localparam int FIELD_DEPTH = 64;
  localparam int MAX_PATTERN = 8;

  localparam int PAT_W  = 64;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = $clog2(FIELD_DEPTH + 1);
  localparam int ADDR_W = $clog2(FIELD_DEPTH);
  localparam int AGE_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef logic [MAX_PATTERN-1:0][7:0] win_t;

  typedef struct packed {
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len;
  } pat_cfg_t;

  typedef struct packed {
    pat_cfg_t start_cfg;
    pat_cfg_t end_cfg;
    pat_cfg_t watch_cfg;
  } cfg_t;

  typedef struct packed {
    logic start_hit;
    logic end_hit;
    logic watch_hit;
  } hit_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] r);
    if (r == '0) begin
      return LEN_W'(1);
    end
    if (r > LEN_W'(MAX_PATTERN)) begin
      return LEN_W'(MAX_PATTERN);
    end
    return r;
  endfunction

  // One cell's share of a tail compare: the cell at a given age is checked
  // against the pattern byte that lines up with it for length n.
  function automatic logic tail_term(input logic [7:0] b, input logic v,
                                     input logic [AGE_W-1:0] age,
                                     input logic [PAT_W-1:0] pat,
                                     input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] age_ext;
    logic [LEN_W-1:0] diff;
    logic [AGE_W-1:0] idx;
    age_ext = LEN_W'(age);
    diff = n - LEN_W'(1) - age_ext;
    idx = diff[AGE_W-1:0];
    if (age_ext >= n) begin
      return 1'b1;
    end
    return v && (b == pat[8*idx +: 8]);
  endfunction

endpackage

// ===== design/delimited_field_extractor_unit.sv =====
// Flow: a clear goes to S_STATUS, which registers its status transaction once the
// output slot is free. A push passes S_COMMIT, which moves 0..8 bytes to the store,
// then S_SHIFT and S_EVAL, then gives a status transaction or reads a completed field
// out byte by byte through S_RD and S_WAIT. No new item is taken until that is done.
// Reset: control state, window valid bits and flags clear; registers take pattern 0,
// length 1; field store contents are undefined until written.
module delimited_field_extractor_unit import dfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [PAT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cmd,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       field_byte,
  output logic             byte_valid,
  output logic             field_done,
  output logic             last,
  output logic             contains_seen,
  output logic             overflow
);

  localparam logic [2:0] REG_START_PAT = 3'd0;
  localparam logic [2:0] REG_START_LEN = 3'd1;
  localparam logic [2:0] REG_END_PAT   = 3'd2;
  localparam logic [2:0] REG_END_LEN   = 3'd3;
  localparam logic [2:0] REG_WATCH_PAT = 3'd4;
  localparam logic [2:0] REG_WATCH_LEN = 3'd5;

  logic [PAT_W-1:0] start_pattern;
  logic [LEN_W-1:0] start_length;
  logic [PAT_W-1:0] end_pattern;
  logic [LEN_W-1:0] end_length;
  logic [PAT_W-1:0] watch_pattern;
  logic [LEN_W-1:0] watch_length;

  cfg_t      cfg;
  win_t      win;
  hit_t      hit_chain [MAX_PATTERN+1];
  cell_ctl_t cell_ctl;
  logic [7:0] item_byte;
  logic [MAX_PATTERN-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern <= '0;
      start_length  <= LEN_W'(1);
      end_pattern   <= '0;
      end_length    <= LEN_W'(1);
      watch_pattern <= '0;
      watch_length  <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_PAT: start_pattern <= cfg_data;
        REG_START_LEN: start_length  <= cfg_data[LEN_W-1:0];
        REG_END_PAT:   end_pattern   <= cfg_data;
        REG_END_LEN:   end_length    <= cfg_data[LEN_W-1:0];
        REG_WATCH_PAT: watch_pattern <= cfg_data;
        REG_WATCH_LEN: watch_length  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.start_cfg.pat = start_pattern;
    cfg.start_cfg.len = clamp_len(start_length);
    cfg.end_cfg.pat   = end_pattern;
    cfg.end_cfg.len   = clamp_len(end_length);
    cfg.watch_cfg.pat = watch_pattern;
    cfg.watch_cfg.len = clamp_len(watch_length);
  end

  assign hit_chain[0] = '{start_hit: 1'b1, end_hit: 1'b1, watch_hit: 1'b1};

  // Cell g holds the byte received g pushes ago; cell 0 takes the new byte.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [7:0] byte_in;
    logic       vld_in;
    if (g == 0) begin : g_head
      assign byte_in = item_byte;
      assign vld_in  = 1'b1;
    end else begin : g_body
      assign byte_in = win[g-1];
      assign vld_in  = vld[g-1];
    end
    dfe_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl),
      .age     (AGE_W'(g)),
      .byte_in (byte_in),
      .vld_in  (vld_in),
      .cfg     (cfg),
      .hit_in  (hit_chain[g]),
      .byte_q  (win[g]),
      .vld_q   (vld[g]),
      .hit_out (hit_chain[g+1])
    );
  end

  dfe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .field_byte    (field_byte),
    .byte_valid    (byte_valid),
    .field_done    (field_done),
    .last          (last),
    .contains_seen (contains_seen),
    .overflow      (overflow),
    .elen          (cfg.end_cfg.len),
    .win           (win),
    .hits          (hit_chain[MAX_PATTERN]),
    .cell_ctl      (cell_ctl),
    .item_byte     (item_byte)
  );

endmodule

// ===== design/dfe_cell.sv =====
module dfe_cell import dfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [AGE_W-1:0] age,
  input  logic [7:0]       byte_in,
  input  logic             vld_in,
  input  cfg_t             cfg,
  input  hit_t             hit_in,
  output logic [7:0]       byte_q,
  output logic             vld_q,
  output hit_t             hit_out
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld_q <= 1'b0;
    end else if (ctl.shift) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_q <= byte_in;
    end
  end

  always_comb begin
    hit_out.start_hit = hit_in.start_hit &&
        tail_term(byte_q, vld_q, age, cfg.start_cfg.pat, cfg.start_cfg.len);
    hit_out.end_hit = hit_in.end_hit &&
        tail_term(byte_q, vld_q, age, cfg.end_cfg.pat, cfg.end_cfg.len);
    hit_out.watch_hit = hit_in.watch_hit &&
        tail_term(byte_q, vld_q, age, cfg.watch_cfg.pat, cfg.watch_cfg.len);
  end

endmodule

// ===== design/dfe_ctrl.sv =====
module dfe_ctrl import dfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cmd,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       field_byte,
  output logic             byte_valid,
  output logic             field_done,
  output logic             last,
  output logic             contains_seen,
  output logic             overflow,
  input  logic [LEN_W-1:0] elen,
  input  win_t             win,
  input  hit_t             hits,
  output cell_ctl_t        cell_ctl,
  output logic [7:0]       item_byte
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_COMMIT = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;
  localparam logic [2:0] S_EMPTY  = 3'd5;
  localparam logic [2:0] S_RD     = 3'd6;
  localparam logic [2:0] S_WAIT   = 3'd7;

  localparam logic [1:0] PH_SEEK    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  logic [2:0]        state;
  logic [1:0]        phase;
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  ep;
  logic              contains;
  logic              ovf;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        rd_data;
  logic [7:0]        mem [FIELD_DEPTH];

  logic              accept;
  logic              slot_free;
  logic              do_commit;
  logic              store_wr;
  logic [LEN_W-1:0]  ep_idx;
  logic [7:0]        commit_byte;
  logic              last_byte;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign slot_free   = !out_valid || !out_stall;
  assign do_commit   = (state == S_COMMIT) && (phase == PH_COLLECT) &&
                       (ep != '0) && (ep >= elen);
  assign store_wr    = do_commit && (count < CNT_W'(FIELD_DEPTH));
  assign ep_idx      = ep - LEN_W'(1);
  assign commit_byte = win[ep_idx[AGE_W-1:0]];
  assign last_byte   = (CNT_W'(rd_idx) + CNT_W'(1)) == count;

  assign cell_ctl.shift = (state == S_SHIFT);
  assign cell_ctl.clear = accept && cmd;

  always_ff @(posedge clk) begin
    if (accept && !cmd) begin
      item_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[count[ADDR_W-1:0]] <= commit_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_SEEK;
      count    <= '0;
      ep       <= '0;
      contains <= 1'b0;
      ovf      <= 1'b0;
      rd_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd) begin
              phase    <= PH_SEEK;
              count    <= '0;
              ep       <= '0;
              contains <= 1'b0;
              ovf      <= 1'b0;
              state    <= S_STATUS;
            end else begin
              state <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          if (do_commit) begin
            if (store_wr) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            ep <= ep - LEN_W'(1);
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (phase == PH_COLLECT) begin
            ep <= ep + LEN_W'(1);
          end
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_STATUS;
          if (hits.watch_hit) begin
            contains <= 1'b1;
          end
          if (phase == PH_SEEK) begin
            if (hits.start_hit) begin
              phase <= PH_COLLECT;
              count <= '0;
              ep    <= '0;
            end
          end else if (phase == PH_COLLECT) begin
            if (ep >= elen && hits.end_hit) begin
              phase  <= PH_DONE;
              ep     <= '0;
              rd_idx <= '0;
              state  <= (count == '0) ? S_EMPTY : S_RD;
            end
          end
        end
        S_STATUS, S_EMPTY: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (slot_free) begin
            rd_idx <= rd_idx + ADDR_W'(1);
            state  <= last_byte ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free &&
                 (state == S_STATUS || state == S_EMPTY || state == S_WAIT)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // flags are captured with the transaction so a later item cannot alter a held result
  always_ff @(posedge clk) begin
    if (slot_free) begin
      case (state)
        S_STATUS: begin
          field_byte    <= '0;
          byte_valid    <= 1'b0;
          field_done    <= 1'b0;
          last          <= 1'b1;
          contains_seen <= contains;
          overflow      <= ovf;
        end
        S_EMPTY: begin
          field_byte    <= '0;
          byte_valid    <= 1'b0;
          field_done    <= 1'b1;
          last          <= 1'b1;
          contains_seen <= contains;
          overflow      <= ovf;
        end
        S_WAIT: begin
          field_byte    <= rd_data;
          byte_valid    <= 1'b1;
          field_done    <= 1'b1;
          last          <= last_byte;
          contains_seen <= contains;
          overflow      <= ovf;
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIELD_DEPTH))
    else $error("field count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> count == CNT_W'(FIELD_DEPTH))
    else $error("overflow flagged with store not full");

  a_done_idle_ep: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> ep == '0)
    else $error("pending end bytes after extraction done");

  a_start_enter: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && phase == PH_SEEK && hits.start_hit) |=>
      (phase == PH_COLLECT && count == '0))
    else $error("start match did not open a fresh field");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && slot_free && last_byte) |=> state == S_IDLE)
    else $error("drain did not finish on last byte");

endmodule
